[src/flow_record_aggregator_defines.svh]
// ----------------------------------------------------------------------------
// Flow record aggregator assertion macros
// Shared concurrent assertion forms, clocked on i_clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef FLOW_RECORD_AGGREGATOR_DEFINES_SVH
`define FLOW_RECORD_AGGREGATOR_DEFINES_SVH

// A condition that must hold at every clock edge.
`define FRA_ASSERT_NOW(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its cause.
`define FRA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// A consequence that must hold in the cycle after its cause.
`define FRA_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[src/fra_pkg.sv]
// ----------------------------------------------------------------------------
// Flow record aggregator package
// Job word passed from the front part to the back part, and fixed codes.
// ----------------------------------------------------------------------------
package fra_pkg;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_V4_LEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_V6_LEN = 2'd2;

    // Aggregation modes.
    localparam logic [2:0] MODE_SRC_PORT = 3'd0;
    localparam logic [2:0] MODE_DST_PORT = 3'd1;
    localparam logic [2:0] MODE_V6_SRC = 3'd2;
    localparam logic [2:0] MODE_V6_DST = 3'd3;
    localparam logic [2:0] MODE_V4_SRC = 3'd4;
    localparam logic [2:0] MODE_V4_DST = 3'd5;

    // Result status codes.
    localparam logic [2:0] ST_ADDED = 3'd0;
    localparam logic [2:0] ST_NEW = 3'd1;
    localparam logic [2:0] ST_SKIP = 3'd2;
    localparam logic [2:0] ST_FULL = 3'd3;
    localparam logic [2:0] ST_RVALID = 3'd4;
    localparam logic [2:0] ST_REMPTY = 3'd5;

    // Prefix limits.
    localparam logic [5:0] V4_BITS = 6'd32;
    localparam logic [7:0] V6_BITS = 8'd128;

    // Hash constants.
    localparam logic [63:0] HASH_MUL_A = 64'hC2B2AE3D27D4EB4F;
    localparam logic [63:0] HASH_MUL_B = 64'h9E3779B97F4A7C15;
    localparam int HASH_BITS = 24;

    typedef enum logic [1:0] {
        K_ACC,
        K_SKIP,
        K_READ,
        K_ROOR
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic        key_fam;
        logic [63:0] key_high;
        logic [63:0] key_low;
        logic [63:0] pkt_cnt;
        logic [63:0] byte_cnt;
    } t_job;

endpackage

[src/fra_ram.sv]
// ----------------------------------------------------------------------------
// Flow record aggregator RAM
// Simple dual port memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module fra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/fra_queue.sv]
// ----------------------------------------------------------------------------
// Flow record aggregator job queue
// Two-entry queue that decouples the front part from the back part.
// ----------------------------------------------------------------------------
module fra_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_head,
    output logic             o_full,
    output logic             o_empty
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_head  = r_mem[r_rp];
    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);

endmodule

[src/fra_front.sv]
// ----------------------------------------------------------------------------
// Flow record aggregator front part
// Holds configuration, forms the key, hashes it to a home slot, queues the job.
// ----------------------------------------------------------------------------
module fra_front
    import fra_pkg::*;
#(
    parameter int TABLE_ENTRIES = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]             i_cfg_index,
    input  logic [CFG_DATA_W-1:0]            i_cfg_data,
    input  logic                             start,
    output logic                             busy,
    input  logic                             i_req_type,
    input  logic                             i_is_ipv6,
    input  logic [63:0]                      i_src_addr_high,
    input  logic [63:0]                      i_src_addr_low,
    input  logic [63:0]                      i_dst_addr_high,
    input  logic [63:0]                      i_dst_addr_low,
    input  logic [15:0]                      i_src_port,
    input  logic [15:0]                      i_dst_port,
    input  logic [63:0]                      i_packet_count,
    input  logic [63:0]                      i_byte_count,
    input  logic [9:0]                       i_entry_index,
    input  logic                             i_clearing,
    input  logic                             i_q_full,
    output logic                             o_q_push,
    output t_job                             o_q_job,
    output logic [$clog2(TABLE_ENTRIES)-1:0] o_q_slot
);

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam bit IS_POW2 = ((TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0);
    localparam int MK = HASH_BITS + IW;
    localparam logic [HASH_BITS:0] RECIP =
        (HASH_BITS + 1)'((64'd1 << MK) / 64'(TABLE_ENTRIES));

    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL,
        F_MOD,
        F_PUSH
    } t_fstate;

    t_fstate          r_state;
    logic [2:0]       r_mode;
    logic [5:0]       r_v4len;
    logic [7:0]       r_v6len;
    t_job             r_job;
    logic [IW-1:0]    r_slot;
    logic [2:0]       r_step;
    logic [63:0]      r_acc;
    logic [63:0]      r_x;
    logic [HASH_BITS-1:0] r_h;
    logic [HASH_BITS-1:0] r_q;
    logic             r_mcnt;

    logic             accept;
    t_job             n_job;
    logic             use_dst;
    logic             is_skip;
    logic [63:0]      addr_hi;
    logic [63:0]      addr_lo;
    logic [6:0]       p4;
    logic [7:0]       p6;
    logic [6:0]       p6_hi;
    logic [6:0]       p6_lo;
    logic [31:0]      op_a;
    logic [31:0]      op_b;
    logic [63:0]      prod;
    logic [63:0]      mul_sum;
    logic [63:0]      mul_src;
    logic [63:0]      mul_const;
    logic             second;
    logic [2*HASH_BITS:0] q_prod;
    logic [2*HASH_BITS:0] q_sh;
    logic [HASH_BITS-1:0] qn;
    logic [HASH_BITS-1:0] rem;

    function automatic logic [63:0] lead_mask(input logic [6:0] p);
        logic [63:0] m;
        if (p == 7'd0) begin
            m = 64'd0;
        end else begin
            m = ~64'd0 << (7'd64 - p);
        end
        return m;
    endfunction

    assign accept   = start && !busy;
    assign busy     = (r_state != F_IDLE) || i_clearing;
    assign o_q_push = (r_state == F_PUSH) && !i_q_full;
    assign o_q_job  = r_job;
    assign o_q_slot = r_slot;

    // Key formation from the record and the configuration.
    always_comb begin
        use_dst = r_mode[0];
        addr_hi = use_dst ? i_dst_addr_high : i_src_addr_high;
        addr_lo = use_dst ? i_dst_addr_low : i_src_addr_low;
        p4      = (r_v4len > V4_BITS) ? 7'(V4_BITS) : {1'b0, r_v4len};
        p6      = (r_v6len > V6_BITS) ? V6_BITS : r_v6len;
        p6_hi   = (p6 >= 8'd64) ? 7'd64 : p6[6:0];
        p6_lo   = (p6 > 8'd64) ? 7'(p6 - 8'd64) : 7'd0;
        is_skip = ((r_mode == MODE_V6_SRC || r_mode == MODE_V6_DST) && !i_is_ipv6) ||
                  ((r_mode == MODE_V4_SRC || r_mode == MODE_V4_DST) && i_is_ipv6);

        n_job.kind     = K_ACC;
        n_job.key_fam  = 1'b0;
        n_job.key_high = 64'd0;
        n_job.key_low  = 64'd0;
        n_job.pkt_cnt  = i_packet_count;
        n_job.byte_cnt = i_byte_count;

        if (i_req_type) begin
            n_job.kind = (32'(i_entry_index) < TABLE_ENTRIES) ? K_READ : K_ROOR;
        end else if (r_mode == MODE_SRC_PORT || r_mode == MODE_DST_PORT) begin
            n_job.key_low = {48'd0, use_dst ? i_dst_port : i_src_port};
        end else if (is_skip) begin
            n_job.kind = K_SKIP;
        end else if (i_is_ipv6) begin
            n_job.key_fam  = 1'b1;
            n_job.key_high = addr_hi & lead_mask(p6_hi);
            n_job.key_low  = addr_lo & lead_mask(p6_lo);
        end else begin
            n_job.key_low = {32'd0, addr_lo[31:0]} & (lead_mask(p4) >> 32);
        end
    end

    // One shared 32x32 multiplier builds each 64-bit truncated product in three steps.
    always_comb begin
        second    = (r_step >= 3'd3);
        mul_src   = second ? r_x : r_job.key_high;
        mul_const = second ? HASH_MUL_B : HASH_MUL_A;
        case (r_step)
            3'd1, 3'd4: begin
                op_a = mul_src[63:32];
                op_b = mul_const[31:0];
            end
            3'd2, 3'd5: begin
                op_a = mul_src[31:0];
                op_b = mul_const[63:32];
            end
            default: begin
                op_a = mul_src[31:0];
                op_b = mul_const[31:0];
            end
        endcase
        prod    = op_a * op_b;
        mul_sum = r_acc + {prod[31:0], 32'd0};
        // The reciprocal quotient is exact or one short, so one subtraction finishes
        // the remainder.
        q_prod  = r_h * RECIP;
        q_sh    = q_prod >> MK;
        qn      = r_q * HASH_BITS'(TABLE_ENTRIES);
        rem     = r_h - qn;
        if (rem >= HASH_BITS'(TABLE_ENTRIES)) begin
            rem = rem - HASH_BITS'(TABLE_ENTRIES);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_mode  <= 3'd0;
            r_v4len <= 6'd32;
            r_v6len <= 8'd128;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_MODE:   r_mode  <= i_cfg_data[2:0];
                    CFG_V4_LEN: r_v4len <= i_cfg_data[5:0];
                    CFG_V6_LEN: r_v6len <= i_cfg_data;
                    default:    ;
                endcase
            end
            case (r_state)
                F_IDLE: begin
                    if (accept) begin
                        r_job  <= n_job;
                        r_slot <= IW'(i_entry_index);
                        r_step <= 3'd0;
                        r_state <= (n_job.kind == K_ACC) ? F_MUL : F_PUSH;
                    end
                end
                F_MUL: begin
                    r_step <= r_step + 3'd1;
                    if (r_step == 3'd0 || r_step == 3'd3) begin
                        r_acc <= prod;
                    end else if (r_step == 3'd1 || r_step == 3'd4) begin
                        r_acc <= mul_sum;
                    end else if (r_step == 3'd2) begin
                        r_x <= mul_sum ^ r_job.key_low ^ {63'd0, r_job.key_fam};
                    end else begin
                        r_h    <= mul_sum[63:40];
                        r_slot <= IS_POW2 ? mul_sum[40 +: IW] : '0;
                        r_mcnt <= 1'b0;
                        r_state <= IS_POW2 ? F_PUSH : F_MOD;
                    end
                end
                F_MOD: begin
                    r_mcnt <= ~r_mcnt;
                    if (!r_mcnt) begin
                        r_q <= q_sh[HASH_BITS-1:0];
                    end else begin
                        r_slot  <= rem[IW-1:0];
                        r_state <= F_PUSH;
                    end
                end
                F_PUSH: begin
                    if (!i_q_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

endmodule

[src/fra_back.sv]
// ----------------------------------------------------------------------------
// Flow record aggregator back part
// Clears the valid store, probes the table, updates entries and drives results.
// ----------------------------------------------------------------------------
module fra_back
    import fra_pkg::*;
#(
    parameter int TABLE_ENTRIES = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_q_empty,
    input  t_job                               i_q_job,
    input  logic [$clog2(TABLE_ENTRIES)-1:0]   i_q_slot,
    output logic                               o_q_pop,
    output logic                               o_clearing,
    output logic                               o_done,
    output logic [2:0]                         o_status,
    output logic [63:0]                        o_key_high,
    output logic [63:0]                        o_key_low,
    output logic                               o_key_is_ipv6,
    output logic [63:0]                        o_packets_total,
    output logic [63:0]                        o_bytes_total,
    output logic [$clog2(TABLE_ENTRIES+1)-1:0] o_entries_used
);

    `include "flow_record_aggregator_defines.svh"

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int DW = 1 + 64 * 4;

    typedef enum logic [1:0] {
        B_CLEAR,
        B_IDLE,
        B_CHECK
    } t_bstate;

    t_bstate       r_state;
    logic [IW-1:0] r_clr;
    t_job          r_job;
    logic [IW-1:0] r_slot;
    logic [CW-1:0] r_n;
    logic [CW-1:0] r_used;
    logic          r_done;
    logic [2:0]    r_status;
    logic [63:0]   r_kh;
    logic [63:0]   r_kl;
    logic          r_fam;
    logic [63:0]   r_pkts;
    logic [63:0]   r_bytes;
    logic [CW-1:0] r_used_out;

    logic          v_we;
    logic [IW-1:0] v_waddr;
    logic          v_wdata;
    logic          v_q;
    logic [IW-1:0] raddr;
    logic          d_we;
    logic [DW-1:0] d_wdata;
    logic [DW-1:0] d_q;
    logic [IW-1:0] slot_next;
    logic          hit;
    logic [63:0]   sum_pk;
    logic [63:0]   sum_by;

    fra_ram #(.WIDTH(1), .DEPTH(TABLE_ENTRIES)) u_valid_ram (
        .i_clk   (i_clk),
        .i_we    (v_we),
        .i_waddr (v_waddr),
        .i_wdata (v_wdata),
        .i_raddr (raddr),
        .o_rdata (v_q)
    );

    fra_ram #(.WIDTH(DW), .DEPTH(TABLE_ENTRIES)) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (d_we),
        .i_waddr (r_slot),
        .i_wdata (d_wdata),
        .i_raddr (raddr),
        .o_rdata (d_q)
    );

    always_comb begin
        slot_next = (r_slot == IW'(TABLE_ENTRIES - 1)) ? '0 : r_slot + 1'b1;
        raddr     = (r_state == B_CHECK) ? slot_next : i_q_slot;
        hit       = v_q && (d_q[256] == r_job.key_fam) && (d_q[255:192] == r_job.key_high) &&
                    (d_q[191:128] == r_job.key_low);
        sum_pk    = d_q[127:64] + r_job.pkt_cnt;
        sum_by    = d_q[63:0] + r_job.byte_cnt;
        o_q_pop   = (r_state == B_IDLE) && !i_q_empty;

        d_we    = (r_state == B_CHECK) && (r_job.kind == K_ACC) && (!v_q || hit);
        d_wdata = v_q ? {r_job.key_fam, r_job.key_high, r_job.key_low, sum_pk, sum_by}
                      : {r_job.key_fam, r_job.key_high, r_job.key_low,
                         r_job.pkt_cnt, r_job.byte_cnt};
        if (r_state == B_CLEAR) begin
            v_we    = 1'b1;
            v_waddr = r_clr;
            v_wdata = 1'b0;
        end else begin
            v_we    = d_we && !v_q;
            v_waddr = r_slot;
            v_wdata = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_CLEAR;
            r_clr   <= '0;
            r_used  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                B_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == IW'(TABLE_ENTRIES - 1)) begin
                        r_state <= B_IDLE;
                    end
                end
                B_IDLE: begin
                    if (!i_q_empty) begin
                        r_job  <= i_q_job;
                        r_slot <= i_q_slot;
                        r_n    <= '0;
                        if (i_q_job.kind == K_SKIP || i_q_job.kind == K_ROOR) begin
                            r_done     <= 1'b1;
                            r_status   <= (i_q_job.kind == K_SKIP) ? ST_SKIP : ST_REMPTY;
                            r_kh       <= 64'd0;
                            r_kl       <= 64'd0;
                            r_fam      <= 1'b0;
                            r_pkts     <= 64'd0;
                            r_bytes    <= 64'd0;
                            r_used_out <= r_used;
                        end else begin
                            r_state <= B_CHECK;
                        end
                    end
                end
                B_CHECK: begin
                    r_used_out <= r_used;
                    if (r_job.kind == K_READ) begin
                        r_done   <= 1'b1;
                        r_status <= v_q ? ST_RVALID : ST_REMPTY;
                        r_fam    <= v_q && d_q[256];
                        r_kh     <= v_q ? d_q[255:192] : 64'd0;
                        r_kl     <= v_q ? d_q[191:128] : 64'd0;
                        r_pkts   <= v_q ? d_q[127:64] : 64'd0;
                        r_bytes  <= v_q ? d_q[63:0] : 64'd0;
                        r_state  <= B_IDLE;
                    end else if (!v_q || hit || r_n == CW'(TABLE_ENTRIES - 1)) begin
                        r_done  <= 1'b1;
                        r_fam   <= r_job.key_fam;
                        r_kh    <= r_job.key_high;
                        r_kl    <= r_job.key_low;
                        r_state <= B_IDLE;
                        if (!v_q) begin
                            r_status   <= ST_NEW;
                            r_pkts     <= r_job.pkt_cnt;
                            r_bytes    <= r_job.byte_cnt;
                            r_used     <= r_used + 1'b1;
                            r_used_out <= r_used + 1'b1;
                        end else if (hit) begin
                            r_status <= ST_ADDED;
                            r_pkts   <= sum_pk;
                            r_bytes  <= sum_by;
                        end else begin
                            r_status <= ST_FULL;
                            r_pkts   <= 64'd0;
                            r_bytes  <= 64'd0;
                        end
                    end else begin
                        r_slot <= slot_next;
                        r_n    <= r_n + 1'b1;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    assign o_clearing      = (r_state == B_CLEAR);
    assign o_done          = r_done;
    assign o_status        = r_status;
    assign o_key_high      = r_kh;
    assign o_key_low       = r_kl;
    assign o_key_is_ipv6   = r_fam;
    assign o_packets_total = r_pkts;
    assign o_bytes_total   = r_bytes;
    assign o_entries_used  = r_used_out;

    `FRA_ASSERT_NOW(a_used_bound, r_used <= CW'(TABLE_ENTRIES), "occupied count above table size")
    `FRA_ASSERT_IMP(a_quiet_clear, r_state == B_CLEAR, !r_done && !o_q_pop, "activity while clearing")
    `FRA_ASSERT_IMP(a_skip_zero, r_done && r_status == ST_SKIP, r_pkts == 64'd0 && r_kl == 64'd0 && r_kh == 64'd0, "skipped record shows data")
    `FRA_ASSERT_NXT(a_probe_follows, o_q_pop && (i_q_job.kind == K_ACC || i_q_job.kind == K_READ), r_state == B_CHECK && !r_done, "table job did not start probing")

endmodule

[src/flow_record_aggregator.sv]
// ----------------------------------------------------------------------------
// Flow record aggregator
// A result comes later for each extra probe, and later again for the modulo step when
// TABLE_ENTRIES is not a power of two. The front hashes one accumulate at a time and
// holds busy meanwhile, while reads and skipped records go to the queue unhashed; the
// queue lets the front take the next record while the back part still probes for the
// last one. After reset the valid store is cleared slot by slot with busy high.
// ----------------------------------------------------------------------------
module flow_record_aggregator
    import fra_pkg::*;
#(
    parameter int TABLE_ENTRIES = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Configuration write channel.
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]               i_cfg_index,
    input  logic [CFG_DATA_W-1:0]              i_cfg_data,
    // Command side.
    input  logic                               start,
    output logic                               busy,
    input  logic                               i_req_type,
    input  logic                               i_is_ipv6,
    input  logic [63:0]                        i_src_addr_high,
    input  logic [63:0]                        i_src_addr_low,
    input  logic [63:0]                        i_dst_addr_high,
    input  logic [63:0]                        i_dst_addr_low,
    input  logic [15:0]                        i_src_port,
    input  logic [15:0]                        i_dst_port,
    input  logic [63:0]                        i_packet_count,
    input  logic [63:0]                        i_byte_count,
    input  logic [9:0]                         i_entry_index,
    // Result side: one word per job, valid for one cycle while o_done is high.
    output logic                               o_done,
    output logic [2:0]                         o_status,
    output logic [63:0]                        o_key_high,
    output logic [63:0]                        o_key_low,
    output logic                               o_key_is_ipv6,
    output logic [63:0]                        o_packets_total,
    output logic [63:0]                        o_bytes_total,
    output logic [$clog2(TABLE_ENTRIES+1)-1:0] o_entries_used
);

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int QW = $bits(t_job) + IW;

    // Front to queue.
    logic          q_push;
    t_job          f_job;
    logic [IW-1:0] f_slot;
    // Queue to back.
    logic          q_pop;
    logic          q_full;
    logic          q_empty;
    logic [QW-1:0] q_head;
    t_job          b_job;
    logic [IW-1:0] b_slot;
    logic          clearing;

    // Change registers only while the block is idle (unchecked); all writes are taken.
    assign o_cfg_ready = 1'b1;

    // The front part owns the configuration, builds the masked key and hashes it.
    fra_front #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .start           (start),
        .busy            (busy),
        .i_req_type      (i_req_type),
        .i_is_ipv6       (i_is_ipv6),
        .i_src_addr_high (i_src_addr_high),
        .i_src_addr_low  (i_src_addr_low),
        .i_dst_addr_high (i_dst_addr_high),
        .i_dst_addr_low  (i_dst_addr_low),
        .i_src_port      (i_src_port),
        .i_dst_port      (i_dst_port),
        .i_packet_count  (i_packet_count),
        .i_byte_count    (i_byte_count),
        .i_entry_index   (i_entry_index),
        .i_clearing      (clearing),
        .i_q_full        (q_full),
        .o_q_push        (q_push),
        .o_q_job         (f_job),
        .o_q_slot        (f_slot)
    );

    // Jobs keep their order through the queue, so results come out in command order.
    fra_queue #(.WIDTH(QW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  ({f_job, f_slot}),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    assign b_job  = q_head[QW-1:IW];
    assign b_slot = q_head[IW-1:0];

    // The back part walks the probe chain one slot per cycle and updates the table.
    fra_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_empty       (q_empty),
        .i_q_job         (b_job),
        .i_q_slot        (b_slot),
        .o_q_pop         (q_pop),
        .o_clearing      (clearing),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_key_high      (o_key_high),
        .o_key_low       (o_key_low),
        .o_key_is_ipv6   (o_key_is_ipv6),
        .o_packets_total (o_packets_total),
        .o_bytes_total   (o_bytes_total),
        .o_entries_used  (o_entries_used)
    );

endmodule

[tb/sv/fra_flow_checker.sv]
// ----------------------------------------------------------------------------
// Flow record aggregator checker
// Watches the configuration, command and result channels, keeps its own copy
// of the aggregation table, and compares every result word with its forecast.
// ----------------------------------------------------------------------------
module fra_flow_checker
    import fra_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                 i_start,
    input  logic                 i_busy,
    input  logic                 i_req_type,
    input  logic                 i_is_ipv6,
    input  logic [63:0]          i_src_addr_high,
    input  logic [63:0]          i_src_addr_low,
    input  logic [63:0]          i_dst_addr_high,
    input  logic [63:0]          i_dst_addr_low,
    input  logic [15:0]          i_src_port,
    input  logic [15:0]          i_dst_port,
    input  logic [63:0]          i_packet_count,
    input  logic [63:0]          i_byte_count,
    input  logic [9:0]           i_entry_index,
    input  logic                 i_done,
    input  logic [2:0]           i_status,
    input  logic [63:0]          i_key_high,
    input  logic [63:0]          i_key_low,
    input  logic                 i_key_is_ipv6,
    input  logic [63:0]          i_packets_total,
    input  logic [63:0]          i_bytes_total,
    input  logic [10:0]          i_entries_used,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_entries
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 1024;

    typedef struct {
        logic [2:0]  status;
        logic [63:0] key_high;
        logic [63:0] key_low;
        logic        key_v6;
        logic [63:0] packets;
        logic [63:0] bytes;
        logic [10:0] used;
    } t_flow_result;

    logic        tbl_valid [SLOTS];
    logic [63:0] tbl_key_high [SLOTS];
    logic [63:0] tbl_key_low [SLOTS];
    logic        tbl_key_v6 [SLOTS];
    logic [63:0] tbl_packets [SLOTS];
    logic [63:0] tbl_bytes [SLOTS];
    int          occupied;

    logic [2:0]  agg_mode;
    logic [5:0]  v4_len;
    logic [7:0]  v6_len;

    t_flow_result pending_results [$];

    assign o_pending = pending_results.size();
    assign o_entries = occupied;

    // Leading-ones mask of a 64-bit word.
    function automatic logic [63:0] lead_ones(int bits);
        if (bits <= 0) return 64'd0;
        if (bits >= 64) return '1;
        return ~64'd0 << (64 - bits);
    endfunction

    function automatic logic [9:0] home_slot(logic [63:0] kh, logic [63:0] kl, logic fam);
        logic [63:0] mixed;
        logic [63:0] spread;
        mixed = (kh * HASH_MUL_A) ^ kl ^ {63'd0, fam};
        spread = mixed * HASH_MUL_B;
        return spread[49:40];
    endfunction

    function automatic t_flow_result aggregate_record();
        t_flow_result r;
        logic         use_dst;
        logic         skip;
        int           plen;
        int           slot;
        logic [63:0]  mask;
        r = '{status: ST_FULL, key_high: 0, key_low: 0, key_v6: 0,
              packets: 0, bytes: 0, used: 0};
        if (i_req_type) begin
            r.status = ST_REMPTY;
            if (tbl_valid[i_entry_index]) begin
                r.status = ST_RVALID;
                r.key_high = tbl_key_high[i_entry_index];
                r.key_low = tbl_key_low[i_entry_index];
                r.key_v6 = tbl_key_v6[i_entry_index];
                r.packets = tbl_packets[i_entry_index];
                r.bytes = tbl_bytes[i_entry_index];
            end
        end else begin
            use_dst = agg_mode[0];
            skip = 1'b0;
            if (agg_mode <= MODE_DST_PORT) begin
                r.key_low = {48'd0, use_dst ? i_dst_port : i_src_port};
            end else begin
                if ((agg_mode == MODE_V6_SRC || agg_mode == MODE_V6_DST) && !i_is_ipv6)
                    skip = 1'b1;
                if ((agg_mode == MODE_V4_SRC || agg_mode == MODE_V4_DST) && i_is_ipv6)
                    skip = 1'b1;
                if (!skip && i_is_ipv6) begin
                    plen = (v6_len > V6_BITS) ? 128 : int'(v6_len);
                    r.key_high = (use_dst ? i_dst_addr_high : i_src_addr_high) & lead_ones(plen);
                    r.key_low = (use_dst ? i_dst_addr_low : i_src_addr_low)
                                & lead_ones(plen - 64);
                    r.key_v6 = 1'b1;
                end else if (!skip) begin
                    plen = (v4_len > V4_BITS) ? 32 : int'(v4_len);
                    mask = lead_ones(plen);
                    r.key_low = {32'd0, (use_dst ? i_dst_addr_low[31:0] : i_src_addr_low[31:0])
                                 & mask[63:32]};
                end
            end
            if (skip) begin
                r.status = ST_SKIP;
            end else begin
                slot = home_slot(r.key_high, r.key_low, r.key_v6);
                for (int n = 0; n < SLOTS; n++) begin
                    if (!tbl_valid[slot]) begin
                        tbl_valid[slot] = 1'b1;
                        tbl_key_high[slot] = r.key_high;
                        tbl_key_low[slot] = r.key_low;
                        tbl_key_v6[slot] = r.key_v6;
                        tbl_packets[slot] = i_packet_count;
                        tbl_bytes[slot] = i_byte_count;
                        occupied++;
                        r.status = ST_NEW;
                    end else if (tbl_key_high[slot] == r.key_high
                                 && tbl_key_low[slot] == r.key_low
                                 && tbl_key_v6[slot] == r.key_v6) begin
                        tbl_packets[slot] += i_packet_count;
                        tbl_bytes[slot] += i_byte_count;
                        r.status = ST_ADDED;
                    end
                    if (r.status != ST_FULL) begin
                        r.packets = tbl_packets[slot];
                        r.bytes = tbl_bytes[slot];
                        break;
                    end
                    slot = (slot + 1) % SLOTS;
                end
            end
        end
        r.used = occupied[10:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] seen, logic [63:0] want);
        $display("%0t mismatch on %s: got %h, expected %h", $realtime, what, seen, want);
        o_fail_count++;
    endtask

    initial o_fail_count = 0;

    always @(posedge i_clk) begin
        t_flow_result want;
        if (!i_rst_n) begin
            for (int s = 0; s < SLOTS; s++) tbl_valid[s] = 1'b0;
            occupied = 0;
            agg_mode = MODE_SRC_PORT;
            v4_len = V4_BITS;
            v6_len = V6_BITS;
            pending_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_MODE: agg_mode = i_cfg_data[2:0];
                    CFG_V4_LEN: v4_len = i_cfg_data[5:0];
                    CFG_V6_LEN: v6_len = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_done) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result word", {61'd0, i_status}, 64'd0);
                end else begin
                    want = pending_results.pop_front();
                    if (i_status !== want.status)
                        report_mismatch("status", {61'd0, i_status}, {61'd0, want.status});
                    if (i_key_high !== want.key_high)
                        report_mismatch("key_high", i_key_high, want.key_high);
                    if (i_key_low !== want.key_low)
                        report_mismatch("key_low", i_key_low, want.key_low);
                    if (i_key_is_ipv6 !== want.key_v6)
                        report_mismatch("key_is_ipv6", {63'd0, i_key_is_ipv6}, {63'd0, want.key_v6});
                    if (i_packets_total !== want.packets)
                        report_mismatch("packets_total", i_packets_total, want.packets);
                    if (i_bytes_total !== want.bytes)
                        report_mismatch("bytes_total", i_bytes_total, want.bytes);
                    if (i_entries_used !== want.used)
                        report_mismatch("entries_used", {53'd0, i_entries_used}, {53'd0, want.used});
                end
            end
            // A new command word is forecast, and a record folded into the table, when it is taken.
            if (i_start && !i_busy) pending_results.push_back(aggregate_record());
        end
    end

endmodule

[tb/sv/tb_flow_record_aggregator.sv]
// ----------------------------------------------------------------------------
// Flow record aggregator testbench
// Drives directed and random flow records and table reads through several
// aggregation settings, then fills the table past capacity; a checker module
// beside the block forecasts and compares every result word.
// ----------------------------------------------------------------------------
module tb_flow_record_aggregator;
    import fra_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // Address modes that take either family have no name in the package.
    localparam logic [2:0] MODE_ANY_SRC = 3'd6;
    localparam logic [2:0] MODE_ANY_DST = 3'd7;
    localparam int RANDOM_PHASES = 8;
    localparam int WORDS_PER_PHASE = 110;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  start;
    logic                  busy;
    logic                  i_req_type;
    logic                  i_is_ipv6;
    logic [63:0]           i_src_addr_high;
    logic [63:0]           i_src_addr_low;
    logic [63:0]           i_dst_addr_high;
    logic [63:0]           i_dst_addr_low;
    logic [15:0]           i_src_port;
    logic [15:0]           i_dst_port;
    logic [63:0]           i_packet_count;
    logic [63:0]           i_byte_count;
    logic [9:0]            i_entry_index;
    logic                  o_done;
    logic [2:0]            o_status;
    logic [63:0]           o_key_high;
    logic [63:0]           o_key_low;
    logic                  o_key_is_ipv6;
    logic [63:0]           o_packets_total;
    logic [63:0]           o_bytes_total;
    logic [10:0]           o_entries_used;

    int fail_count;
    int words_in_flight;
    int table_entries;

    // Small pools of addresses and ports make records hit existing keys often.
    logic [63:0] addr_pool [8];
    logic [15:0] port_pool [8];
    bit          allow_idle;

    flow_record_aggregator uut (.*);

    fra_flow_checker checker_i (
        .i_clk, .i_rst_n,
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .i_start(start), .i_busy(busy),
        .i_req_type, .i_is_ipv6, .i_src_addr_high, .i_src_addr_low,
        .i_dst_addr_high, .i_dst_addr_low, .i_src_port, .i_dst_port,
        .i_packet_count, .i_byte_count, .i_entry_index,
        .i_done(o_done), .i_status(o_status), .i_key_high(o_key_high),
        .i_key_low(o_key_low), .i_key_is_ipv6(o_key_is_ipv6),
        .i_packets_total(o_packets_total), .i_bytes_total(o_bytes_total),
        .i_entries_used(o_entries_used),
        .o_fail_count(fail_count), .o_pending(words_in_flight), .o_entries(table_entries)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Filling the table to the brim makes late records probe long runs, and every
    // record against a full table walks all slots, so the bound is very loose.
    initial begin
        #50ms;
        $display("FAIL flow_record_aggregator");
        $finish;
    end

    // Lower start at a falling edge and hold it low for a random burst.
    task automatic idle_burst();
        int gap;
        gap = $urandom_range(1, 6);
        @(negedge i_clk);
        start = 1'b0;
        repeat (gap - 1) @(negedge i_clk);
    endtask

    // Present one command word at a falling edge and hold it until it is taken.
    // Start stays high afterwards so back-to-back words need no gap.
    task automatic send_word(logic req, logic v6, logic [63:0] sh, logic [63:0] sl,
                             logic [63:0] dh, logic [63:0] dl, logic [15:0] sp,
                             logic [15:0] dp, logic [63:0] pk, logic [63:0] by,
                             logic [9:0] idx);
        if (allow_idle && $urandom_range(0, 3) == 0) idle_burst();
        @(negedge i_clk);
        start = 1'b1;
        i_req_type = req;
        i_is_ipv6 = v6;
        i_src_addr_high = sh;
        i_src_addr_low = sl;
        i_dst_addr_high = dh;
        i_dst_addr_low = dl;
        i_src_port = sp;
        i_dst_port = dp;
        i_packet_count = pk;
        i_byte_count = by;
        i_entry_index = idx;
        do @(posedge i_clk); while (busy);
    endtask

    // Wait until every forecast result has come back and the block is idle.
    task automatic drain();
        @(negedge i_clk);
        start = 1'b0;
        while (words_in_flight != 0 || busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Registers are only written with the command side drained.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_config(logic [2:0] mode, logic [5:0] v4, logic [7:0] v6);
        drain();
        write_reg(CFG_MODE, {5'd0, mode});
        write_reg(CFG_V4_LEN, {2'd0, v4});
        write_reg(CFG_V6_LEN, v6);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] pick_addr();
        logic [63:0] a;
        a = addr_pool[$urandom_range(0, 7)];
        // Sometimes flip a few low bits so that short prefixes still merge.
        if ($urandom_range(0, 2) == 0) a ^= 64'($urandom_range(0, 255));
        if ($urandom_range(0, 7) == 0) a = rand64();
        return a;
    endfunction

    function automatic logic [15:0] pick_port();
        return ($urandom_range(0, 3) == 0) ? 16'($urandom) : port_pool[$urandom_range(0, 7)];
    endfunction

    // Counts are mostly random, with some near the top to make sums wrap.
    function automatic logic [63:0] pick_count();
        case ($urandom_range(0, 3))
            0: return ~64'd0 - 64'($urandom_range(0, 3));
            1: return 64'($urandom_range(0, 100));
            default: return rand64();
        endcase
    endfunction

    task automatic send_random_word();
        logic [63:0] sh, sl, dh, dl;
        sh = pick_addr();
        sl = pick_addr();
        dh = pick_addr();
        dl = pick_addr();
        if ($urandom_range(0, 9) == 0)
            send_word(1'b1, 1'($urandom_range(0, 1)), rand64(), rand64(), rand64(), rand64(),
                      16'($urandom), 16'($urandom), rand64(), rand64(),
                      10'($urandom_range(0, 1023)));
        else
            send_word(1'b0, 1'($urandom_range(0, 1)), sh, sl, dh, dl, pick_port(), pick_port(),
                      pick_count(), pick_count(), 10'($urandom));
    endtask

    initial begin
        logic [5:0]  v4_choice;
        logic [7:0]  v6_choice;
        logic [15:0] next_port;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        start = 1'b0;
        i_req_type = 1'b0;
        i_is_ipv6 = 1'b0;
        i_src_addr_high = '0;
        i_src_addr_low = '0;
        i_dst_addr_high = '0;
        i_dst_addr_low = '0;
        i_src_port = '0;
        i_dst_port = '0;
        i_packet_count = '0;
        i_byte_count = '0;
        i_entry_index = '0;
        allow_idle = 1'b0;
        for (int i = 0; i < 8; i++) begin
            addr_pool[i] = rand64();
            port_pool[i] = 16'($urandom);
        end
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed words at the reset settings: port keys at both ends, a repeat
        // that adds to its entry and wraps the sums, and reads at both ends.
        send_word(1'b0, 1'b0, '0, '0, '0, '0, 16'h0000, 16'hFFFF, ~64'd0, ~64'd0, '0);
        send_word(1'b0, 1'b1, '1, '1, '1, '1, 16'hFFFF, 16'h0000, 64'd1, 64'd1, '1);
        send_word(1'b0, 1'b0, '0, '0, '0, '0, 16'h0000, 16'h1234, 64'd2, 64'd3, '0);
        send_word(1'b1, 1'b0, '0, '0, '0, '0, '0, '0, '0, '0, 10'd0);
        send_word(1'b1, 1'b0, '0, '0, '0, '0, '0, '0, '0, '0, 10'd1023);

        // Destination ports, then IPv6-only with an IPv4 record (skipped) and a
        // record that keeps its whole address.
        set_config(MODE_DST_PORT, 6'd32, 8'd128);
        send_word(1'b0, 1'b0, '0, '0, '0, '0, 16'h0001, 16'hFFFF, 64'd5, 64'd6, '0);
        set_config(MODE_V6_SRC, 6'd32, 8'd128);
        send_word(1'b0, 1'b0, '1, '1, '1, '1, '0, '0, 64'd1, 64'd1, '0);
        send_word(1'b0, 1'b1, '1, '1, '0, '0, '0, '0, 64'd1, 64'd1, '0);

        // IPv4-only destination with an IPv6 record (skipped), and a prefix
        // length above 32 that keeps the whole address.
        set_config(MODE_V4_DST, 6'd63, 8'd255);
        send_word(1'b0, 1'b1, '0, '0, '1, '1, '0, '0, 64'd1, 64'd1, '0);
        send_word(1'b0, 1'b0, '0, '0, '0, 64'hFFFF_FFFF_FFFF_FFFF, '0, '0, 64'd7, 64'd8, '0);
        set_config(MODE_V6_DST, 6'd32, 8'd255);
        send_word(1'b0, 1'b1, '0, '0, '1, '1, '0, '0, 64'd9, 64'd9, '0);

        // Zero prefixes merge every record of a family into one key.
        set_config(MODE_ANY_SRC, 6'd0, 8'd0);
        send_word(1'b0, 1'b0, '1, '1, '0, '0, '0, '0, 64'd1, 64'd2, '0);
        send_word(1'b0, 1'b0, '0, 64'hDEAD_BEEF, '0, '0, '0, '0, 64'd3, 64'd4, '0);
        send_word(1'b0, 1'b1, '1, '1, '0, '0, '0, '0, 64'd1, 64'd2, '0);
        send_word(1'b0, 1'b1, '0, 64'h1, '0, '0, '0, '0, 64'd1, 64'd2, '0);
        set_config(MODE_ANY_DST, 6'd17, 8'd64);
        send_word(1'b0, 1'b1, '0, '0, 64'h0123_4567_89AB_CDEF, '1, '0, '0, 64'd1, 64'd1, '0);
        send_word(1'b0, 1'b0, '0, '0, '0, 64'h89AB_CDEF, '0, '0, 64'd1, 64'd1, '0);
        set_config(MODE_V4_SRC, 6'd1, 8'd65);
        send_word(1'b0, 1'b0, '0, 64'h8000_0000, '0, '0, '0, '0, 64'd1, 64'd1, '0);
        send_word(1'b0, 1'b0, '0, 64'h7FFF_FFFF, '0, '0, '0, '0, 64'd1, 64'd1, '0);

        // Random phases, one per mode, with prefix lengths drawn from the
        // extremes as well as from anywhere in the register's range.
        allow_idle = 1'b1;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case ($urandom_range(0, 3))
                0: v4_choice = 6'd0;
                1: v4_choice = 6'd32;
                2: v4_choice = 6'd63;
                default: v4_choice = 6'($urandom);
            endcase
            case ($urandom_range(0, 4))
                0: v6_choice = 8'd0;
                1: v6_choice = 8'd64;
                2: v6_choice = 8'd128;
                3: v6_choice = 8'd255;
                default: v6_choice = 8'($urandom);
            endcase
            set_config(3'(ph), v4_choice, v6_choice);
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                send_random_word();
                // The sender holds off once per phase until all results are in.
                if (n == WORDS_PER_PHASE / 2) drain();
            end
        end

        // Last part, without idling: new source ports until the table is full,
        // then records that find no room and reads of the full table.
        allow_idle = 1'b0;
        set_config(MODE_SRC_PORT, 6'd32, 8'd128);
        next_port = 16'($urandom);
        while (table_entries < 1024) begin
            send_word(1'b0, 1'b0, rand64(), rand64(), rand64(), rand64(), next_port,
                      16'($urandom), pick_count(), pick_count(), 10'($urandom));
            next_port++;
            // Start drops while the back part catches up, so no word is taken twice.
            @(negedge i_clk);
            start = 1'b0;
            while (words_in_flight > 4) @(posedge i_clk);
        end
        for (int n = 0; n < 30; n++) begin
            if (n % 2 == 0)
                send_word(1'b0, 1'b0, '0, '0, '0, '0, next_port + 16'(n), 16'($urandom),
                          64'd1, 64'd1, '0);
            else
                send_word(1'b1, 1'b0, '0, '0, '0, '0, '0, '0, '0, '0,
                          10'($urandom_range(0, 1023)));
        end
        drain();
        repeat (40) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("PASS flow_record_aggregator");
        end else begin
            $display("FAIL flow_record_aggregator");
        end
        $finish;
    end

endmodule
